// File: rtl/subtractive_random_generator_macros.svh
// ----------------------------------------------------------------------------
// Subtractive random generator assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_MACROS_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

`define SRG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

`define SRG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`else

`define SRG_ASSERT_IMP(label, clk, rst, ante, cons)

`define SRG_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/srg_pkg.sv
// ----------------------------------------------------------------------------
// Subtractive random generator package
// Widths, constants, shared types, the modular subtract and the index step.
// ----------------------------------------------------------------------------
package srg_pkg;

   localparam int unsigned TABLE_LEN     = 55;
   localparam int unsigned ADDR_W        = 6;
   localparam int unsigned RAW_W         = 30;
   localparam int unsigned SEED_W        = 24;
   localparam int unsigned LIMIT_W       = 31;
   localparam int unsigned PROD_W        = RAW_W + LIMIT_W;
   localparam int unsigned REQ_DATA_W    = 56;
   localparam int unsigned RSP_DATA_W    = 64;
   localparam int unsigned FILL_STRIDE   = 21;
   localparam int unsigned FILL_STEPS    = 54;
   localparam int unsigned PARTNER_START = 31;
   localparam int unsigned MIX_OFFSET    = 31;
   localparam int unsigned MIX_SPLIT     = TABLE_LEN - MIX_OFFSET;
   localparam int unsigned MIX_PASSES    = 4;
   localparam int unsigned PASS_W        = $clog2(MIX_PASSES);
   localparam int unsigned EST_W         = 32;

   localparam logic [RAW_W-1:0]  MODULUS   = RAW_W'(1000000000);
   localparam logic [SEED_W-1:0] SEED_BASE = SEED_W'(16183398);

   // The top product bits times this reciprocal undershoot the quotient by
   // at most two.
   localparam logic [EST_W-1:0] RECIP_BILLION = EST_W'((64'd1 << PROD_W) / 64'(MODULUS));

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [RAW_W-1:0]  wr_data;
   } ram_req_type;

   typedef struct packed {
      logic               start;
      logic [LIMIT_W-1:0] limit;
      logic [RAW_W-1:0]   raw;
   } scale_req_type;

   typedef struct packed {
      logic               done;
      logic [RAW_W-1:0]   raw;
      logic [LIMIT_W-1:0] scaled;
   } scale_rsp_type;

   function automatic logic [RAW_W-1:0] sub_mod(input logic [RAW_W-1:0] a,
                                                 input logic [RAW_W-1:0] b);
      return (a >= b) ? (a - b) : (a - b + MODULUS);
   endfunction

   function automatic logic [ADDR_W-1:0] step_index(input logic [ADDR_W-1:0] idx);
      return (idx >= ADDR_W'(TABLE_LEN)) ? ADDR_W'(1) : idx + ADDR_W'(1);
   endfunction

endpackage

// File: rtl/subtractive_random_generator.sv
// ----------------------------------------------------------------------------
// Subtractive random generator
// Lagged subtractive generator modulo one billion over a 55-entry table held
// in a two-read, one-write synchronous memory. Each request beat yields one
// response beat with the next raw value and floor(range_limit * raw / 10^9).
// A plain draw runs the table read and write-back, then the scaler steps (the
// range multiply, a reciprocal estimate of the quotient, the remainder and a
// final correction), then loads the output register, from which the response
// beat is offered, and returns to idle, where the next beat is taken; the load
// waits while an earlier response is still unaccepted. A reseed beat, and the
// first beat after reset, first rebuild the table with 55 fill writes and 220
// pipelined mixing steps. A finished response waits in an output register
// while the next request is already being worked on.
// ----------------------------------------------------------------------------
`include "subtractive_random_generator_macros.svh"

module subtractive_random_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [23:0] seed_magnitude, [54:24] range_limit, [55] zero
   input  logic [srg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] action
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [29:0] raw_value, [60:30] scaled_value, [63:61] zero
   output logic [srg_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import srg_pkg::*;

   ram_req_type        ram_req;
   scale_req_type      scale_req;
   scale_rsp_type      scale_rsp;
   logic [RAW_W-1:0]   rd_data_a;
   logic [RAW_W-1:0]   rd_data_b;
   logic               out_free;
   logic               out_load;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0]   rsp_raw_ff, rsp_raw_in;
   logic [LIMIT_W-1:0] rsp_scaled_ff, rsp_scaled_in;

   srg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_seed   (req_tdata[SEED_W-1:0]),
      .req_limit  (req_tdata[SEED_W +: LIMIT_W]),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .ram_req    (ram_req),
      .scale_req  (scale_req),
      .scale_rsp  (scale_rsp),
      .out_free   (out_free),
      .out_load   (out_load)
   );

   srg_table_ram u_table (
      .clock     (clock),
      .req       (ram_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   srg_scaler u_scaler (
      .clock (clock),
      .reset (reset),
      .req   (scale_req),
      .rsp   (scale_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_raw_in    = rsp_raw_ff;
      rsp_scaled_in = rsp_scaled_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_raw_in    = scale_rsp.raw;
         rsp_scaled_in = scale_rsp.scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_raw_ff    <= rsp_raw_in;
      rsp_scaled_ff <= rsp_scaled_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RAW_W - LIMIT_W)'(0), rsp_scaled_ff, rsp_raw_ff};

   `SRG_ASSERT_IMP(a_no_rw_overlap, clock, reset, ram_req.wr_en && ram_req.rd_en, (ram_req.wr_addr != ram_req.rd_addr_a) && (ram_req.wr_addr != ram_req.rd_addr_b))
   `SRG_ASSERT_IMP(a_wr_addr_range, clock, reset, ram_req.wr_en, (ram_req.wr_addr != '0) && (ram_req.wr_addr <= ADDR_W'(TABLE_LEN)))
   `SRG_ASSERT_IMP(a_no_overwrite, clock, reset, out_load, !rsp_valid_ff || rsp_tready)
   `SRG_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

// File: rtl/srg_table_ram.sv
// ----------------------------------------------------------------------------
// Subtractive random generator lag table
// Two registered read ports and one write port over the 55 table entries.
// ----------------------------------------------------------------------------
module srg_table_ram (
   input  logic                        clock,
   input  srg_pkg::ram_req_type        req,
   output logic [srg_pkg::RAW_W-1:0]   rd_data_a,
   output logic [srg_pkg::RAW_W-1:0]   rd_data_b
);
   import srg_pkg::*;

   logic [RAW_W-1:0] mem_ff [0:TABLE_LEN];
   logic [RAW_W-1:0] rd_a_ff;
   logic [RAW_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_a_ff <= mem_ff[req.rd_addr_a];
         rd_b_ff <= mem_ff[req.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/srg_scaler.sv
// ----------------------------------------------------------------------------
// Subtractive random generator scaler
// Forms range times raw in one multiply, then divides by one billion through
// a reciprocal estimate, a remainder and one correction step.
// ----------------------------------------------------------------------------
module srg_scaler (
   input  logic                   clock,
   input  logic                   reset,
   input  srg_pkg::scale_req_type req,
   output srg_pkg::scale_rsp_type rsp
);
   import srg_pkg::*;

   localparam logic [2:0] SC_IDLE = 3'd0;
   localparam logic [2:0] SC_MUL  = 3'd1;
   localparam logic [2:0] SC_EST  = 3'd2;
   localparam logic [2:0] SC_REM  = 3'd3;
   localparam logic [2:0] SC_FIX  = 3'd4;
   localparam logic [2:0] SC_DONE = 3'd5;

   localparam logic [EST_W-1:0] MOD_ONCE  = EST_W'(MODULUS);
   localparam logic [EST_W-1:0] MOD_TWICE = MOD_ONCE << 1;

   logic [2:0]           state_ff, state_in;
   logic [RAW_W-1:0]     raw_ff, raw_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [LIMIT_W-1:0]   quo_ff, quo_in;
   logic [EST_W-1:0]     rem_ff, rem_in;
   logic [PROD_W-1:0]    product;
   logic [2*EST_W-1:0]   estimate;
   logic [EST_W-1:0]     back_product;

   assign product      = PROD_W'(limit_ff) * PROD_W'(raw_ff);
   assign estimate     = (2*EST_W)'(prod_ff[PROD_W-1 -: EST_W]) * (2*EST_W)'(RECIP_BILLION);
   assign back_product = EST_W'(quo_ff) * MOD_ONCE;

   always_comb begin
      state_in = state_ff;
      raw_in   = raw_ff;
      limit_in = limit_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (req.start) begin
         raw_in   = req.raw;
         limit_in = req.limit;
         state_in = SC_MUL;
      end else begin
         unique case (state_ff)
            SC_MUL: begin
               prod_in  = product;
               state_in = SC_EST;
            end
            SC_EST: begin
               quo_in   = estimate[EST_W +: LIMIT_W];
               state_in = SC_REM;
            end
            SC_REM: begin
               rem_in   = prod_ff[EST_W-1:0] - back_product;
               state_in = SC_FIX;
            end
            SC_FIX: begin
               priority if (rem_ff >= MOD_TWICE) begin
                  quo_in = quo_ff + LIMIT_W'(2);
               end else if (rem_ff >= MOD_ONCE) begin
                  quo_in = quo_ff + LIMIT_W'(1);
               end else begin
                  quo_in = quo_ff;
               end
               state_in = SC_DONE;
            end
            SC_IDLE, SC_DONE: begin
               state_in = state_ff;
            end
            default: begin
               state_in = SC_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      raw_ff   <= raw_in;
      limit_ff <= limit_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   assign rsp.done   = (state_ff == SC_DONE);
   assign rsp.raw    = raw_ff;
   assign rsp.scaled = quo_ff;

endmodule

// File: rtl/srg_ctrl.sv
// ----------------------------------------------------------------------------
// Subtractive random generator sequencer
// Runs the table fill, the pipelined mixing passes and the draw
// read-modify-write, and hands each raw value to the scaler.
// ----------------------------------------------------------------------------
module srg_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [srg_pkg::SEED_W-1:0]    req_seed,
   input  logic [srg_pkg::LIMIT_W-1:0]   req_limit,
   input  logic [srg_pkg::RAW_W-1:0]     rd_data_a,
   input  logic [srg_pkg::RAW_W-1:0]     rd_data_b,
   output srg_pkg::ram_req_type          ram_req,
   output srg_pkg::scale_req_type        scale_req,
   input  srg_pkg::scale_rsp_type        scale_rsp,
   input  logic                          out_free,
   output logic                          out_load
);
   import srg_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FILL    = 3'd1;
   localparam logic [2:0] ST_MIX     = 3'd2;
   localparam logic [2:0] ST_DRAW_RD = 3'd3;
   localparam logic [2:0] ST_DRAW_WR = 3'd4;
   localparam logic [2:0] ST_SCALE   = 3'd5;

   function automatic logic [ADDR_W-1:0] mix_other(input logic [ADDR_W-1:0] idx);
      return (idx <= ADDR_W'(MIX_SPLIT)) ? idx + ADDR_W'(MIX_OFFSET)
                                         : idx - ADDR_W'(MIX_SPLIT);
   endfunction

   logic [2:0]         state_ff, state_in;
   logic               seeded_ff, seeded_in;
   logic [ADDR_W-1:0]  read_idx_ff, read_idx_in;
   logic [ADDR_W-1:0]  partner_idx_ff, partner_idx_in;
   logic [ADDR_W-1:0]  fill_pos_ff, fill_pos_in;
   logic [ADDR_W-1:0]  fill_cnt_ff, fill_cnt_in;
   logic [ADDR_W-1:0]  mix_idx_ff, mix_idx_in;
   logic [PASS_W-1:0]  mix_pass_ff, mix_pass_in;
   logic               mix_wr_valid_ff, mix_wr_valid_in;
   logic [ADDR_W-1:0]  mix_wr_addr_ff, mix_wr_addr_in;
   logic [RAW_W-1:0]   prev_ff, prev_in;
   logic [RAW_W-1:0]   cur_ff, cur_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               accept;
   logic [SEED_W-1:0]  seed_clamped;
   logic [ADDR_W:0]    fill_sum;
   logic [ADDR_W-1:0]  fill_pos_nx;
   logic [ADDR_W-1:0]  read_idx_nx;
   logic [ADDR_W-1:0]  partner_idx_nx;
   logic [RAW_W-1:0]   rmw_diff;

   assign req_ready      = (state_ff == ST_IDLE);
   assign accept         = req_valid && req_ready;
   assign seed_clamped   = (req_seed > SEED_BASE) ? SEED_BASE : req_seed;
   assign fill_sum       = {1'b0, fill_pos_ff} + (ADDR_W + 1)'(FILL_STRIDE);
   assign fill_pos_nx    = (fill_sum >= (ADDR_W + 1)'(TABLE_LEN))
                           ? ADDR_W'(fill_sum - (ADDR_W + 1)'(TABLE_LEN))
                           : fill_sum[ADDR_W-1:0];
   assign read_idx_nx    = step_index(read_idx_ff);
   assign partner_idx_nx = step_index(partner_idx_ff);
   assign rmw_diff       = sub_mod(rd_data_a, rd_data_b);

   always_comb begin
      state_in        = state_ff;
      seeded_in       = seeded_ff;
      read_idx_in     = read_idx_ff;
      partner_idx_in  = partner_idx_ff;
      fill_pos_in     = fill_pos_ff;
      fill_cnt_in     = fill_cnt_ff;
      mix_idx_in      = mix_idx_ff;
      mix_pass_in     = mix_pass_ff;
      mix_wr_valid_in = 1'b0;
      mix_wr_addr_in  = mix_wr_addr_ff;
      prev_in         = prev_ff;
      cur_in          = cur_ff;
      limit_in        = limit_ff;
      ram_req         = '0;
      scale_req.start = 1'b0;
      scale_req.limit = limit_ff;
      scale_req.raw   = rmw_diff;
      out_load        = 1'b0;

      if (mix_wr_valid_ff) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = mix_wr_addr_ff;
         ram_req.wr_data = rmw_diff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               limit_in = req_limit;
               if (req_action || !seeded_ff) begin
                  prev_in     = RAW_W'(SEED_BASE - seed_clamped);
                  cur_in      = RAW_W'(1);
                  fill_pos_in = ADDR_W'(TABLE_LEN);
                  fill_cnt_in = '0;
                  state_in    = ST_FILL;
               end else begin
                  state_in = ST_DRAW_RD;
               end
            end
         end
         ST_FILL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = fill_pos_ff;
            ram_req.wr_data = (fill_cnt_ff == '0) ? prev_ff : cur_ff;
            fill_pos_in     = fill_pos_nx;
            fill_cnt_in     = fill_cnt_ff + ADDR_W'(1);
            if (fill_cnt_ff != '0) begin
               cur_in  = sub_mod(prev_ff, cur_ff);
               prev_in = cur_ff;
            end
            if (fill_cnt_ff == ADDR_W'(FILL_STEPS)) begin
               mix_idx_in  = ADDR_W'(1);
               mix_pass_in = '0;
               state_in    = ST_MIX;
            end
         end
         ST_MIX: begin
            ram_req.rd_en     = 1'b1;
            ram_req.rd_addr_a = mix_idx_ff;
            ram_req.rd_addr_b = mix_other(mix_idx_ff);
            mix_wr_valid_in   = 1'b1;
            mix_wr_addr_in    = mix_idx_ff;
            if (mix_idx_ff == ADDR_W'(TABLE_LEN)) begin
               mix_idx_in  = ADDR_W'(1);
               mix_pass_in = mix_pass_ff + PASS_W'(1);
               if (mix_pass_ff == PASS_W'(MIX_PASSES - 1)) begin
                  read_idx_in    = '0;
                  partner_idx_in = ADDR_W'(PARTNER_START);
                  seeded_in      = 1'b1;
                  state_in       = ST_DRAW_RD;
               end
            end else begin
               mix_idx_in = mix_idx_ff + ADDR_W'(1);
            end
         end
         ST_DRAW_RD: begin
            ram_req.rd_en     = 1'b1;
            ram_req.rd_addr_a = read_idx_nx;
            ram_req.rd_addr_b = partner_idx_nx;
            read_idx_in       = read_idx_nx;
            partner_idx_in    = partner_idx_nx;
            state_in          = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = read_idx_ff;
            ram_req.wr_data = rmw_diff;
            scale_req.start = 1'b1;
            state_in        = ST_SCALE;
         end
         ST_SCALE: begin
            if (scale_rsp.done && out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         seeded_ff       <= 1'b0;
         read_idx_ff     <= '0;
         partner_idx_ff  <= ADDR_W'(PARTNER_START);
         mix_wr_valid_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         seeded_ff       <= seeded_in;
         read_idx_ff     <= read_idx_in;
         partner_idx_ff  <= partner_idx_in;
         mix_wr_valid_ff <= mix_wr_valid_in;
      end
      fill_pos_ff    <= fill_pos_in;
      fill_cnt_ff    <= fill_cnt_in;
      mix_idx_ff     <= mix_idx_in;
      mix_pass_ff    <= mix_pass_in;
      mix_wr_addr_ff <= mix_wr_addr_in;
      prev_ff        <= prev_in;
      cur_ff         <= cur_in;
      limit_ff       <= limit_in;
   end

endmodule
